### rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define KPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define KPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/kpc_pkg.sv
// Package for the key press classifier: widths, codes, register indexes and
// the configuration and state structs. No dependencies.
package kpc_pkg;

  localparam int unsigned CodeW    = 8;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned RelW     = 8;
  localparam int unsigned RelLimW  = 7;
  localparam int unsigned DebW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    ACT_SCAN   = 2'd0,
    ACT_REMOTE = 2'd1,
    ACT_ACK    = 2'd2
  } action_e;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_CODE  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LONG_CODE   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_REMOTE_STOP = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_COMBINED    = 3'd6;

  localparam logic [RelW-1:0] RELEASE_PARK = 8'd100;

  typedef struct packed {
    logic [DebW-1:0]    debounce_ticks;
    logic [HoldW-1:0]   long_press_ticks;
    logic [RelLimW-1:0] release_ticks;
    logic [CodeW-1:0]   short_code;
    logic [CodeW-1:0]   long_code;
    logic [CodeW-1:0]   remote_stop_code;
    logic [CodeW-1:0]   combined_code;
  } kpc_cfg_t;

  typedef struct packed {
    logic [CodeW-1:0] current_code;
    logic             handled;
    logic             sample_now;
    logic             sample_prev;
    logic [HoldW-1:0] hold_count;
    logic [RelW-1:0]  release_count;
    logic             short_armed;
  } kpc_state_t;

endpackage

### rtl/kpc_cfg.sv
// Configuration register file of the key press classifier.
// Depends on kpc_pkg.
module kpc_cfg
  import kpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output kpc_cfg_t            cfg_o
);

  kpc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= 8'd6;
      cfg_q.long_press_ticks <= 16'd450;
      cfg_q.release_ticks    <= 7'd19;
      cfg_q.short_code       <= 8'd1;
      cfg_q.long_code        <= 8'd2;
      cfg_q.remote_stop_code <= 8'd3;
      cfg_q.combined_code    <= 8'd4;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEBOUNCE:    cfg_q.debounce_ticks   <= cfg_wdata_i[DebW-1:0];
        CFG_LONG_PRESS:  cfg_q.long_press_ticks <= cfg_wdata_i[HoldW-1:0];
        CFG_RELEASE:     cfg_q.release_ticks    <= cfg_wdata_i[RelLimW-1:0];
        CFG_SHORT_CODE:  cfg_q.short_code       <= cfg_wdata_i[CodeW-1:0];
        CFG_LONG_CODE:   cfg_q.long_code        <= cfg_wdata_i[CodeW-1:0];
        CFG_REMOTE_STOP: cfg_q.remote_stop_code <= cfg_wdata_i[CodeW-1:0];
        CFG_COMBINED:    cfg_q.combined_code    <= cfg_wdata_i[CodeW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/kpc_update.sv
// Next-state logic of the key press classifier for one item.
// Depends on kpc_pkg.
module kpc_update
  import kpc_pkg::*;
(
  input  kpc_cfg_t         cfg_i,
  input  kpc_state_t       state_i,
  input  logic [1:0]       action_i,
  input  logic             button_down_i,
  input  logic [CodeW-1:0] remote_code_i,
  output kpc_state_t       state_o
);

  kpc_state_t       nxt;
  logic             frozen;
  logic [HoldW-1:0] hold_inc;
  logic [RelW-1:0]  rel_inc;

  always_comb begin
    nxt      = state_i;
    frozen   = (state_i.current_code != '0) && !state_i.handled;
    hold_inc = (state_i.hold_count != '1) ? state_i.hold_count + 16'd1
                                          : state_i.hold_count;
    rel_inc  = state_i.release_count + 8'd1;
    case (action_i)
      ACT_SCAN: begin
        // Hold everything while a code waits for its acknowledge
        if (!frozen) begin
          nxt.sample_prev = state_i.sample_now;
          nxt.sample_now  = button_down_i;
          if (button_down_i && state_i.sample_now) begin
            nxt.hold_count    = hold_inc;
            nxt.release_count = '0;
            if (hold_inc >= {8'd0, cfg_i.debounce_ticks}) begin
              if (hold_inc > cfg_i.long_press_ticks) begin
                nxt.current_code = cfg_i.long_code;
                nxt.hold_count   = '0;
                nxt.short_armed  = 1'b0;
              end else begin
                nxt.short_armed = 1'b1;
              end
            end
          end else if (!button_down_i) begin
            if (state_i.short_armed) begin
              nxt.current_code = cfg_i.short_code;
              nxt.short_armed  = 1'b0;
            end else begin
              nxt.hold_count    = '0;
              nxt.release_count = rel_inc;
              if (rel_inc > {1'b0, cfg_i.release_ticks}) begin
                nxt.release_count = RELEASE_PARK;
                nxt.handled       = 1'b0;
                nxt.current_code  = '0;
              end
            end
          end
        end
      end
      ACT_REMOTE: begin
        if ((state_i.current_code == '0) && !state_i.sample_now) begin
          nxt.current_code = remote_code_i;
          if (remote_code_i != '0) begin
            nxt.handled = 1'b0;
          end
        end else if (remote_code_i == cfg_i.remote_stop_code) begin
          nxt.handled      = 1'b0;
          nxt.current_code = cfg_i.combined_code;
        end
      end
      ACT_ACK: begin
        nxt.handled = 1'b1;
      end
      default: ;
    endcase
    state_o = nxt;
  end

endmodule

### rtl/key_press_classifier.sv
// Top level of the key press classifier: input register, state update and
// result register. Depends on kpc_pkg, kpc_cfg, kpc_update, assert_macros.svh.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | action_i, button_down_i, remote_code_i
//  out     | source    | out_valid_o / out_stall_i| key_code_o, pending_o
//  cfg     | sink      | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// One item per clock cycle sustained while the result side does not stall; each
// result passes through the input register, then the result register, on its way
// to the outputs. The state update is combinational compare-and-count logic, so
// a new item can follow the last one without a gap.
// Reset clears the handshake, the classifier state and the configuration to
// its defaults. A stall on the result side holds the result register and
// backs up into the input register; no item is dropped or repeated.
`include "assert_macros.svh"

module key_press_classifier
  import kpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          action_i,
  input  logic                button_down_i,
  input  logic [CodeW-1:0]    remote_code_i,
  // results
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CodeW-1:0]    key_code_o,
  output logic                pending_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  kpc_cfg_t cfg;

  // Input register
  logic             in_valid_q;
  logic [1:0]       action_q;
  logic             button_q;
  logic [CodeW-1:0] remote_q;

  // Classifier state
  kpc_state_t state_q, state_d;

  // Result register
  logic             out_valid_q;
  logic [CodeW-1:0] key_code_q;
  logic             pending_q;

  logic out_free;     // result register can take a new result this cycle
  logic advance;      // item moves from input register through the update
  logic in_take;      // new item accepted into the input register
  logic scan_frozen;  // advancing scan meets a code awaiting its acknowledge

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  kpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  kpc_update u_update (
    .cfg_i         (cfg),
    .state_i       (state_q),
    .action_i      (action_q),
    .button_down_i (button_q),
    .remote_code_i (remote_q),
    .state_o       (state_d)
  );

  // Input register: fill when accepted, drain when the item advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q <= action_i;
      button_q <= button_down_i;
      remote_q <= remote_code_i;
    end
  end

  // Classifier state: update only as an item advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: report the state after the update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      key_code_q <= state_d.current_code;
      pending_q  <= (state_d.current_code != '0) && !state_d.handled;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_code_o  = key_code_q;
  assign pending_o   = pending_q;

  assign scan_frozen = advance && (action_q == ACT_SCAN) &&
                       (state_q.current_code != '0) && !state_q.handled;

  // An item held back by a stall stays in the input register
  `KPC_ASSERT(a_hold_input, in_stall_o |=> in_valid_q, "input item lost under stall")
  // A pending result always carries a nonzero code
  `KPC_ASSERT(a_pending_code, out_valid_q && pending_q |-> key_code_q != '0, "pending, no code")
  // A scan while a code awaits its acknowledge leaves the hold count alone
  `KPC_ASSERT(a_frozen_scan, scan_frozen |=> $stable(state_q.hold_count), "scan not frozen")
  // Stall on the input side only ever reflects a full input register
  `KPC_ASSERT_ALWAYS(a_stall_full, in_stall_o |-> in_valid_q, "stall without item")

endmodule

### test/kpc_result_checker.sv
// Result checker for the key press classifier bench: follows the register
// writes, predicts every result from its own copy of the classifier state and
// compares it field by field. Depends on kpc_pkg.
module kpc_result_checker
  import kpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [1:0]          action_i,
  input  logic                button_down_i,
  input  logic [CodeW-1:0]    remote_code_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [CodeW-1:0]    key_code_i,
  input  logic                pending_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  mismatches_o,
  output int                  awaited_o
);

  typedef struct packed {
    logic [CodeW-1:0] key_code;
    logic             pending;
  } key_report_t;

  localparam kpc_cfg_t SettingsAtReset = '{
    debounce_ticks:   8'd6,
    long_press_ticks: 16'd450,
    release_ticks:    7'd19,
    short_code:       8'd1,
    long_code:        8'd2,
    remote_stop_code: 8'd3,
    combined_code:    8'd4
  };

  kpc_cfg_t    settings;
  kpc_state_t  key_state;
  key_report_t key_report_q[$];
  key_report_t want;
  int          miss_count;

  // Next classifier state for one item.
  function automatic kpc_state_t classify_item(kpc_state_t s, kpc_cfg_t c, logic [1:0] act,
                                               logic level, logic [CodeW-1:0] rcode);
    case (action_e'(act))
      ACT_SCAN: begin
        // frozen while a code waits for its acknowledge
        if (s.current_code == '0 || s.handled) begin
          s.sample_prev = s.sample_now;
          s.sample_now  = level;
          if (s.sample_now && s.sample_prev) begin
            if (s.hold_count != '1) s.hold_count = s.hold_count + 1'b1;
            s.release_count = '0;
            if (s.hold_count >= HoldW'(c.debounce_ticks)) begin
              if (s.hold_count > c.long_press_ticks) begin
                s.current_code = c.long_code;
                s.hold_count   = '0;
                s.short_armed  = 1'b0;
              end else begin
                s.short_armed = 1'b1;
              end
            end
          end else if (!s.sample_now) begin
            if (s.short_armed) begin
              s.current_code = c.short_code;
              s.short_armed  = 1'b0;
            end else begin
              s.hold_count    = '0;
              s.release_count = s.release_count + 1'b1;
              if (s.release_count > RelW'(c.release_ticks)) begin
                s.release_count = RELEASE_PARK;
                s.handled       = 1'b0;
                s.current_code  = '0;
              end
            end
          end
        end
      end
      ACT_REMOTE: begin
        if (s.current_code == '0 && !s.sample_now) begin
          s.current_code = rcode;
          if (rcode != '0) s.handled = 1'b0;
        end else if (rcode == c.remote_stop_code) begin
          s.handled      = 1'b0;
          s.current_code = c.combined_code;
        end
      end
      ACT_ACK: s.handled = 1'b1;
      default: ;
    endcase
    return s;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, exp_val, $realtime);
    miss_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings   = SettingsAtReset;
      key_state  = '0;
      miss_count = 0;
      key_report_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (key_report_q.size() == 0) begin
          report_mismatch("result with none awaited, key_code", key_code_i, -1);
        end else begin
          want = key_report_q.pop_front();
          if (key_code_i !== want.key_code) report_mismatch("key_code", key_code_i, want.key_code);
          if (pending_i !== want.pending) report_mismatch("pending", pending_i, want.pending);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEBOUNCE:    settings.debounce_ticks   = cfg_wdata_i[DebW-1:0];
          CFG_LONG_PRESS:  settings.long_press_ticks = cfg_wdata_i[HoldW-1:0];
          CFG_RELEASE:     settings.release_ticks    = cfg_wdata_i[RelLimW-1:0];
          CFG_SHORT_CODE:  settings.short_code       = cfg_wdata_i[CodeW-1:0];
          CFG_LONG_CODE:   settings.long_code        = cfg_wdata_i[CodeW-1:0];
          CFG_REMOTE_STOP: settings.remote_stop_code = cfg_wdata_i[CodeW-1:0];
          CFG_COMBINED:    settings.combined_code    = cfg_wdata_i[CodeW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        key_state = classify_item(key_state, settings, action_i, button_down_i, remote_code_i);
        want.key_code = key_state.current_code;
        want.pending  = (key_state.current_code != '0) && !key_state.handled;
        key_report_q.push_back(want);
      end
    end
    mismatches_o <= miss_count;
    awaited_o    <= key_report_q.size();
  end

endmodule

### test/tb_key_press_classifier.sv
// Top of the key press classifier bench: clock, reset, item and register
// stimulus, result-side stalls and the verdict. Depends on kpc_pkg,
// key_press_classifier and kpc_result_checker.
module tb_key_press_classifier;
  import kpc_pkg::*;

  localparam int PhaseItems    = 250;
  localparam int HoldOffCycles = 300;
  localparam int CycleLimit    = 200000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [1:0]          action_i      = ACT_SCAN;
  logic                button_down_i = 1'b0;
  logic [CodeW-1:0]    remote_code_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [CodeW-1:0]    key_code_o;
  logic                pending_o;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = CFG_DEBOUNCE;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;

  int          mismatch_count;
  int          results_awaited;
  int          items_sent     = 0;
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  logic        hold_off_req   = 1'b0;
  logic        hold_off_done  = 1'b0;
  int          hold_off_left  = 0;
  int unsigned cycle_count    = 0;
  kpc_cfg_t    cfg_now;

  always #6 clk_i = ~clk_i;

  key_press_classifier DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .button_down_i,
    .remote_code_i,
    .out_valid_o,
    .out_stall_i,
    .key_code_o,
    .pending_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i
  );

  kpc_result_checker u_check (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i    (in_stall_o),
    .action_i,
    .button_down_i,
    .remote_code_i,
    .out_valid_i   (out_valid_o),
    .out_stall_i,
    .key_code_i    (key_code_o),
    .pending_i     (pending_o),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .mismatches_o  (mismatch_count),
    .awaited_o     (results_awaited)
  );

  // Result side: one stall decision per edge. When asked, hold the stall for a
  // long stretch while the sender keeps offering, so the block backs up and
  // stalls its own input.
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i   <= 1'b1;
      hold_off_left = hold_off_left - 1;
    end else if (hold_off_req && !hold_off_done) begin
      out_stall_i   <= 1'b1;
      hold_off_left = HoldOffCycles;
      hold_off_done = 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Guard against a hang: give up well past the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one item after an optional random gap and hold it until accepted.
  // Valid is only lowered during a gap, so back-to-back items keep it high.
  task automatic send_item(input action_e act, input logic level, input logic [CodeW-1:0] rcode);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    button_down_i <= level;
    remote_code_i <= rcode;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Stop offering, wait for every awaited result, then allow the two-stage
  // pipeline a few spare cycles.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_awaited != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Write the whole register set from cfg_now; only call while idle.
  task automatic load_settings();
    write_reg(CFG_DEBOUNCE,    CfgDataW'(cfg_now.debounce_ticks));
    write_reg(CFG_LONG_PRESS,  CfgDataW'(cfg_now.long_press_ticks));
    write_reg(CFG_RELEASE,     CfgDataW'(cfg_now.release_ticks));
    write_reg(CFG_SHORT_CODE,  CfgDataW'(cfg_now.short_code));
    write_reg(CFG_LONG_CODE,   CfgDataW'(cfg_now.long_code));
    write_reg(CFG_REMOTE_STOP, CfgDataW'(cfg_now.remote_stop_code));
    write_reg(CFG_COMBINED,    CfgDataW'(cfg_now.combined_code));
    cfg_we_i <= 1'b0;
  endtask

  // Remote code for a remote check: favour the stop code and the empty code.
  function automatic logic [CodeW-1:0] remote_pick();
    case ($urandom_range(0, 5))
      0, 1:    return cfg_now.remote_stop_code;
      2:       return '0;
      default: return CodeW'($urandom);
    endcase
  endfunction

  initial begin
    int held;
    int released;
    int pick;
    int phase_end;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset settings: empty remote while idle, remote load while
    // idle, scan frozen by a pending code, stop code while busy, acknowledge,
    // foreign remote while busy.
    send_item(ACT_REMOTE, 1'b0, 8'h00);
    send_item(ACT_REMOTE, 1'b0, 8'h03);
    send_item(ACT_SCAN,   1'b1, 8'h00);
    send_item(ACT_REMOTE, 1'b0, 8'h03);
    send_item(ACT_ACK,    1'b0, 8'h00);
    send_item(ACT_REMOTE, 1'b0, 8'hC8);
    settle();

    // Directed, tight timing: debounce of one, long limit of three, clear on
    // the first released tick.
    cfg_now = '{debounce_ticks: 8'd1, long_press_ticks: 16'd3, release_ticks: 7'd0,
                short_code: 8'hFF, long_code: 8'h01, remote_stop_code: 8'hAA,
                combined_code: 8'h55};
    load_settings();
    send_item(ACT_SCAN,   1'b0, 8'h00);   // release clears the old code
    send_item(ACT_SCAN,   1'b1, 8'h00);   // fresh press
    send_item(ACT_SCAN,   1'b1, 8'hFF);   // debounced: short press armed
    send_item(ACT_SCAN,   1'b0, 8'h00);   // release reports the short code
    send_item(ACT_SCAN,   1'b1, 8'h00);   // frozen
    send_item(ACT_ACK,    1'b1, 8'h00);
    send_item(ACT_REMOTE, 1'b0, 8'hAA);   // stop code forces the combined code
    send_item(ACT_ACK,    1'b0, 8'h00);
    repeat (5) send_item(ACT_SCAN, 1'b1, 8'h00);   // held past the long limit
    send_item(ACT_ACK,    1'b0, 8'h00);
    send_item(ACT_SCAN,   1'b1, 8'h00);   // still held: re-arm
    send_item(ACT_SCAN,   1'b0, 8'h00);
    send_item(ACT_ACK,    1'b0, 8'h00);
    send_item(ACT_SCAN,   1'b0, 8'h00);   // idle release clears
    send_item(ACT_REMOTE, 1'b0, 8'hFF);   // remote load of the widest code
    send_item(ACT_ACK,    1'b0, 8'h00);

    // Random phases: six register settings, extremes included. Idling runs
    // sender-light first, then receiver-light, then none at all.
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      cfg_now.short_code       = CodeW'($urandom_range(1, 255));
      cfg_now.long_code        = CodeW'($urandom_range(1, 255));
      cfg_now.remote_stop_code = CodeW'($urandom_range(1, 255));
      cfg_now.combined_code    = CodeW'($urandom_range(1, 255));
      case (phase)
        0: begin
          cfg_now.debounce_ticks   = 8'd4;
          cfg_now.long_press_ticks = 16'd60;
          cfg_now.release_ticks    = 7'd19;
        end
        1: begin
          cfg_now = '{debounce_ticks: 8'd1, long_press_ticks: 16'd1, release_ticks: 7'd0,
                      short_code: 8'd1, long_code: 8'd255, remote_stop_code: 8'd255,
                      combined_code: 8'd1};
        end
        2: begin
          cfg_now.debounce_ticks   = 8'd3;
          cfg_now.long_press_ticks = 16'd40;
          cfg_now.release_ticks    = 7'd5;
        end
        3: begin
          cfg_now = '{debounce_ticks: 8'd255, long_press_ticks: 16'd300, release_ticks: 7'd99,
                      short_code: 8'd255, long_code: 8'd1, remote_stop_code: 8'd1,
                      combined_code: 8'd255};
        end
        4: begin
          cfg_now.debounce_ticks   = 8'd2;
          cfg_now.long_press_ticks = 16'd20;
          cfg_now.release_ticks    = 7'd10;
        end
        default: begin
          cfg_now.debounce_ticks   = 8'd255;
          cfg_now.long_press_ticks = 16'd65000;
          cfg_now.release_ticks    = 7'd99;
        end
      endcase
      send_gap_pct   = (phase < 2) ? 11 : (phase < 4) ? 57 : 0;
      recv_stall_pct <= (phase < 2) ? 57 : (phase < 4) ? 11 : 0;
      load_settings();
      if (phase == 4) hold_off_req <= 1'b1;

      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // Press of random length: short of debounce, just past it, or
          // past the long limit where that stays affordable.
          case ($urandom_range(0, 9))
            0, 1:    held = $urandom_range(1, cfg_now.debounce_ticks);
            7, 8, 9: held = (cfg_now.long_press_ticks > 400) ?
                            cfg_now.debounce_ticks + $urandom_range(1, 6) :
                            cfg_now.long_press_ticks + $urandom_range(2, 4);
            default: held = cfg_now.debounce_ticks + $urandom_range(1, 6);
          endcase
          released = $urandom_range(1, cfg_now.release_ticks + 3);
          for (int i = 0; i < held; i++) begin
            if ($urandom_range(0, 99) < 2) send_item(ACT_REMOTE, 1'($urandom), remote_pick());
            send_item(ACT_SCAN, 1'b1, CodeW'($urandom));
          end
          // Acknowledge mostly, so the release ticks are not all frozen.
          if ($urandom_range(0, 4) != 0) send_item(ACT_ACK, 1'($urandom), CodeW'($urandom));
          for (int i = 0; i < released; i++) begin
            send_item(ACT_SCAN, 1'b0, CodeW'($urandom));
            if (i == 0 && $urandom_range(0, 4) != 0)
              send_item(ACT_ACK, 1'($urandom), CodeW'($urandom));
          end
        end else if (pick < 70) begin
          send_item(ACT_ACK, 1'($urandom), CodeW'($urandom));
        end else if (pick < 85) begin
          send_item(ACT_REMOTE, 1'($urandom), remote_pick());
        end else begin
          // Noise: anything in range, in any order.
          repeat ($urandom_range(1, 4))
            send_item(action_e'($urandom_range(0, 2)), 1'($urandom), CodeW'($urandom));
        end
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
